@@ rtl/page_frame_bitmap_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_defines
// assertion macros used by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PFBA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define PFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pfba_pkg.sv @@
// ----------------------------------------------------------------------------
// pfba_pkg
// shared types, codes and constants of the page frame bitmap allocator
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int unsigned MapWordsDefault = 1024;
  localparam int unsigned WordBits        = 32;
  localparam int unsigned PageBits        = 20;
  localparam int unsigned PageCntBits     = 21;
  localparam int unsigned ResBits         = 16;
  localparam int unsigned OpBits          = 3;
  localparam int unsigned StatusBits      = 3;

  localparam logic [OpBits-1:0] OP_INIT     = 3'd0;
  localparam logic [OpBits-1:0] OP_ALLOC    = 3'd1;
  localparam logic [OpBits-1:0] OP_ALLOC_AT = 3'd2;
  localparam logic [OpBits-1:0] OP_FREE     = 3'd3;
  localparam logic [OpBits-1:0] OP_QUERY    = 3'd4;

  localparam logic [StatusBits-1:0] ST_OK        = 3'd0;
  localparam logic [StatusBits-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [StatusBits-1:0] ST_NOT_FREE  = 3'd2;
  localparam logic [StatusBits-1:0] ST_PROTECTED = 3'd3;
  localparam logic [StatusBits-1:0] ST_DOUBLE    = 3'd4;
  localparam logic [StatusBits-1:0] ST_RANGE     = 3'd5;

  typedef enum logic [1:0] {
    UK_FILL,
    UK_SCAN,
    UK_SET,
    UK_CLR
  } unit_kind_e;

  typedef struct packed {
    unit_kind_e               kind;
    logic [WordBits-1:0]      word;
    logic [4:0]               bit_idx;
    logic [PageCntBits-1:0]   base;
    logic [PageCntBits-1:0]   limit;
  } unit_req_t;

  typedef struct packed {
    logic [WordBits-1:0] wdata;
    logic                hit;
    logic                not_full;
    logic [4:0]          first_zero;
  } unit_rsp_t;

endpackage

@@ rtl/page_frame_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// bitmap page frame allocator: init, alloc, alloc at address, free, query
// ----------------------------------------------------------------------------
// alloc at address, free and query: accept, then read, check and result
// alloc: each map word is read and checked in turn up to the first non-full word
// init: writes all MAP_WORDS words, one word written per cycle; one item at a time
// out of range and unused codes: go straight to the result
// after reset a clearing pass over all MAP_WORDS words runs before the first transaction
// the reserved_pages register resets to 0 and is writable at any time
`include "page_frame_bitmap_allocator_defines.svh"

module page_frame_bitmap_allocator import pfba_pkg::*; #(
  parameter int unsigned MAP_WORDS = MapWordsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [31:0] address
  input  logic [OpBits-1:0]     s_axis_tuser,   // [2:0] operation
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // [31:0] page_address, [32] page_free
  output logic [StatusBits-1:0] m_axis_tuser,   // [2:0] status
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [ResBits-1:0]    cfg_data_i
);

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [PageCntBits-1:0] TotalPages = PageCntBits'(MAP_WORDS * 32);
  localparam logic [AW-1:0] LastIdx = AW'(MAP_WORDS - 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_INIT     = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_RMW_RD   = 3'd5;
  localparam logic [2:0] S_RMW_CHK  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [PageCntBits-1:0] lim_q, lim_d;
  logic [OpBits-1:0]      op_q, op_d;
  logic [PageBits-1:0]    page_q, page_d;
  logic [ResBits-1:0]     reserved_q;

  logic [31:0]            res_addr_q, res_addr_d;
  logic [StatusBits-1:0]  res_st_q, res_st_d;
  logic                   res_free_q, res_free_d;

  logic                   m_valid_q, m_valid_d;
  logic [31:0]            m_addr_q, m_addr_d;
  logic [StatusBits-1:0]  m_st_q, m_st_d;
  logic                   m_free_q, m_free_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  logic [WordBits-1:0]    ram_rdata;
  logic [AW-1:0]          page_idx;
  logic [PageCntBits-1:0] res_ext;
  logic                   in_accept;
  logic                   in_range;
  unit_req_t              ureq;
  unit_rsp_t              ursp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign page_idx      = page_q[5 +: AW];
  assign in_range      = (32'(s_axis_tdata[31:17]) < 32'(MAP_WORDS));
  assign res_ext       = PageCntBits'(reserved_q);

  pfba_ram #(
    .Width (WordBits),
    .Depth (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ursp.wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ureq.word    = ram_rdata;
    ureq.bit_idx = page_q[4:0];
    ureq.base    = PageCntBits'({idx_q, 5'b0});
    ureq.limit   = lim_q;
    priority if (state_q == S_INIT || state_q == S_CLEAR) begin
      ureq.kind = UK_FILL;
    end else if (state_q == S_SCAN_CHK) begin
      ureq.kind = UK_SCAN;
    end else if (op_q == OP_FREE) begin
      ureq.kind = UK_CLR;
    end else begin
      ureq.kind = UK_SET;
    end
  end

  pfba_word_unit u_unit (
    .req_i (ureq),
    .rsp_o (ursp)
  );

  assign ram_raddr = (state_q == S_SCAN_RD) ? idx_q : page_idx;
  assign ram_waddr = (state_q == S_RMW_CHK) ? page_idx : idx_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    lim_d      = lim_q;
    op_d       = op_q;
    page_d     = page_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    res_free_d = res_free_q;
    ram_we     = 1'b0;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_addr_d   = m_addr_q;
    m_st_d     = m_st_q;
    m_free_d   = m_free_q;

    unique case (state_q)
      S_CLEAR, S_INIT: begin
        ram_we = 1'b1;
        if (idx_q == LastIdx) begin
          res_addr_d = '0;
          res_st_d   = ST_OK;
          res_free_d = 1'b0;
          state_d    = (state_q == S_INIT) ? S_DONE : S_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          op_d       = s_axis_tuser;
          page_d     = s_axis_tdata[31:12];
          idx_d      = '0;
          res_addr_d = '0;
          res_st_d   = ST_OK;
          res_free_d = 1'b0;
          unique case (s_axis_tuser)
            OP_INIT: begin
              lim_d   = (res_ext < TotalPages) ? res_ext : TotalPages;
              state_d = S_INIT;
            end
            OP_ALLOC: state_d = S_SCAN_RD;
            OP_ALLOC_AT, OP_FREE, OP_QUERY: begin
              if (in_range) begin
                state_d = S_RMW_RD;
              end else begin
                res_st_d = ST_RANGE;
                state_d  = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (ursp.not_full) begin
          ram_we     = 1'b1;
          res_addr_d = {PageBits'({idx_q, ursp.first_zero}), 12'b0};
          state_d    = S_DONE;
        end else if (idx_q == LastIdx) begin
          res_st_d = ST_NO_FREE;
          state_d  = S_DONE;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_RMW_RD: state_d = S_RMW_CHK;
      S_RMW_CHK: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_ALLOC_AT: begin
            if (ursp.hit) begin
              res_st_d = ST_NOT_FREE;
            end else begin
              ram_we     = 1'b1;
              res_addr_d = {page_q, 12'b0};
            end
          end
          OP_FREE: begin
            priority if (PageCntBits'(page_q) < res_ext) begin
              res_st_d = ST_PROTECTED;
            end else if (!ursp.hit) begin
              res_st_d = ST_DOUBLE;
            end else begin
              ram_we     = 1'b1;
              res_addr_d = {page_q, 12'b0};
            end
          end
          OP_QUERY: begin
            res_addr_d = {page_q, 12'b0};
            res_free_d = !ursp.hit;
          end
          default: res_st_d = ST_OK;
        endcase
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_addr_d  = res_addr_q;
          m_st_d    = res_st_q;
          m_free_d  = res_free_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      idx_q      <= '0;
      lim_q      <= '0;
      m_valid_q  <= 1'b0;
      reserved_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      lim_q     <= lim_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        reserved_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    page_q     <= page_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    res_free_q <= res_free_d;
    m_addr_q   <= m_addr_d;
    m_st_q     <= m_st_d;
    m_free_q   <= m_free_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_free_q, m_addr_q};
  assign m_axis_tuser  = m_st_q;

  `PFBA_ASSERT_NOW(a_we_state, clk_i, rst_ni, ram_we, (state_q == S_CLEAR || state_q == S_INIT || state_q == S_SCAN_CHK || state_q == S_RMW_CHK), "map written outside a write state")
  `PFBA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, (state_q != S_IDLE), "sequencer stayed idle after a transaction")
  `PFBA_ASSERT_NOW(a_scan_write, clk_i, rst_ni, (state_q == S_SCAN_CHK && ursp.not_full), ram_we, "scan found a clear bit but did not set it")
  `PFBA_ASSERT_NEXT(a_done_load, clk_i, rst_ni, (state_q == S_DONE && !m_valid_q), (m_valid_q && state_q == S_IDLE), "result not loaded into the output register")

endmodule

@@ rtl/pfba_ram.sv @@
// ----------------------------------------------------------------------------
// pfba_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pfba_word_unit.sv @@
// ----------------------------------------------------------------------------
// pfba_word_unit
// shared per-word unit: fill mask, first clear bit search, bit set and clear
// ----------------------------------------------------------------------------
module pfba_word_unit import pfba_pkg::*; (
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  logic [4:0]             first_zero;
  logic                   not_full;
  logic [4:0]             sel_bit;
  logic [WordBits-1:0]    onehot;
  logic [WordBits-1:0]    fill;
  logic [PageCntBits-1:0] diff;

  // lowest page number sits at the msb
  always_comb begin
    first_zero = 5'd31;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (!req_i.word[WordBits-1-b]) begin
        first_zero = 5'(b);
      end
    end
  end

  assign not_full = ~&req_i.word;
  assign sel_bit  = (req_i.kind == UK_SCAN) ? first_zero : req_i.bit_idx;
  assign onehot   = 32'h8000_0000 >> sel_bit;

  // pages base .. base+31 set where below limit
  assign diff = req_i.limit - req_i.base;
  always_comb begin
    if (req_i.limit <= req_i.base) begin
      fill = '0;
    end else if (diff >= PageCntBits'(WordBits)) begin
      fill = '1;
    end else begin
      fill = ~(32'hFFFF_FFFF >> diff[4:0]);
    end
  end

  always_comb begin
    unique case (req_i.kind)
      UK_FILL: rsp_o.wdata = fill;
      UK_SCAN: rsp_o.wdata = req_i.word | onehot;
      UK_SET:  rsp_o.wdata = req_i.word | onehot;
      UK_CLR:  rsp_o.wdata = req_i.word & ~onehot;
      default: rsp_o.wdata = req_i.word;
    endcase
  end

  assign rsp_o.hit        = |(req_i.word & onehot);
  assign rsp_o.not_full   = not_full;
  assign rsp_o.first_zero = first_zero;

endmodule

@@ dv/tb_page_frame_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_page_frame_bitmap_allocator
// Self-checking bench for the page frame bitmap allocator. A driver feeds
// requests and register writes from a pre-built queue. A shadow copy of the
// page map predicts each response, and a monitor compares it field by field.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_page_frame_bitmap_allocator;
  import pfba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MapWords    = MapWordsDefault;
  localparam int unsigned MaxPages    = MapWords * WordBits;
  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned RandomItems = 1850;
  localparam int unsigned TailCycles  = 2 * MapWords + 16;
  localparam longint      TimeoutNs   = 64'd150_000_000;

  localparam logic [31:0] LastPageAddr = 32'((MaxPages - 1) << 12);
  localparam logic [31:0] FirstOutAddr = 32'(MaxPages << 12);
  localparam logic [OpBits-1:0] OP_TOP = {OpBits{1'b1}};

  typedef enum logic [1:0] {
    REQ_ITEM,
    REQ_CFG,
    REQ_DRAIN
  } req_kind_e;

  typedef struct {
    req_kind_e         kind;
    logic [OpBits-1:0] op;
    logic [31:0]       addr;
    logic [ResBits-1:0] cfg;
    int unsigned       gap;
  } alloc_req_t;

  typedef struct packed {
    logic [31:0]           page_address;
    logic [StatusBits-1:0] status;
    logic                  page_free;
  } frame_outcome_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;
  logic [OpBits-1:0]     s_axis_tuser  = OP_INIT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;
  logic [StatusBits-1:0] m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [ResBits-1:0]    cfg_data_i    = '0;

  // shadow state of the allocator
  logic [WordBits-1:0] shadow_map [MapWords] = '{default: '0};
  logic [ResBits-1:0]  shadow_reserved = '0;

  alloc_req_t     request_q [$];
  frame_outcome_t outcome_q [$];

  alloc_req_t  cur_req;
  bit          have_req   = 1'b0;
  int unsigned gap_left   = 0;
  logic        valid_nxt;
  logic        cfg_nxt;
  bit          src_quiet  = 1'b0;

  int unsigned sink_stall = 0;
  int unsigned sink_calm  = 0;

  int unsigned mismatches    = 0;
  int unsigned requests_done = 0;
  int unsigned cfg_writes    = 0;
  int unsigned results_seen  = 0;
  int unsigned status_hits [8] = '{default: 0};

  page_frame_bitmap_allocator #(
    .MAP_WORDS(MapWords)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] address
    .s_axis_tuser  (s_axis_tuser),   // [2:0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] page_address, [32] page_free
    .m_axis_tuser  (m_axis_tuser),   // [2:0] status
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // applies one request to the shadow map and returns the response it gives
  function automatic frame_outcome_t page_map_outcome(input logic [OpBits-1:0] op,
                                                      input logic [31:0] addr);
    frame_outcome_t res;
    logic [19:0]    page;
    logic [14:0]    word;
    logic [31:0]    mask;
    int unsigned    n;
    int unsigned    lo;
    int unsigned    b;
    bit             found;
    res   = '{page_address: '0, status: ST_OK, page_free: 1'b0};
    page  = addr[31:12];
    word  = page[19:5];
    mask  = 32'h8000_0000 >> page[4:0];
    found = 1'b0;
    if (op == OP_INIT) begin
      n = (shadow_reserved < MaxPages) ? shadow_reserved : MaxPages;
      for (int unsigned w = 0; w < MapWords; w++) begin
        lo = w * WordBits;
        if (n >= lo + WordBits) shadow_map[w] = '1;
        else if (n > lo) shadow_map[w] = ~(32'hFFFF_FFFF >> (n - lo));
        else shadow_map[w] = '0;
      end
    end else if (op == OP_ALLOC) begin
      for (int unsigned w = 0; w < MapWords && !found; w++) begin
        if (shadow_map[w] != '1) begin
          b = 0;
          while (b < WordBits - 1 && shadow_map[w][WordBits-1-b]) b++;
          shadow_map[w][WordBits-1-b] = 1'b1;
          res.page_address = 32'((w * WordBits + b) << 12);
          found = 1'b1;
        end
      end
      if (!found) res.status = ST_NO_FREE;
    end else if (op > OP_QUERY) begin
      // unused codes do nothing
    end else if (int'(word) >= MapWords) begin
      res.status = ST_RANGE;
    end else if (op == OP_ALLOC_AT) begin
      if ((shadow_map[word] & mask) != 0) begin
        res.status = ST_NOT_FREE;
      end else begin
        shadow_map[word] = shadow_map[word] | mask;
        res.page_address = {page, 12'h000};
      end
    end else if (op == OP_FREE) begin
      if (page < shadow_reserved) begin
        res.status = ST_PROTECTED;
      end else if ((shadow_map[word] & mask) == 0) begin
        res.status = ST_DOUBLE;
      end else begin
        shadow_map[word] = shadow_map[word] & ~mask;
        res.page_address = {page, 12'h000};
      end
    end else begin
      res.page_address = {page, 12'h000};
      res.page_free    = ((shadow_map[word] & mask) == 0);
    end
    return res;
  endfunction

  function automatic void add_item(input logic [OpBits-1:0] op, input logic [31:0] addr);
    alloc_req_t r;
    r.kind = REQ_ITEM;
    r.op   = op;
    r.addr = addr;
    r.cfg  = '0;
    r.gap  = src_quiet ? 0 : $urandom_range(0, 3);
    request_q.push_back(r);
  endfunction

  function automatic void add_cfg(input int unsigned value);
    alloc_req_t r;
    r.kind = REQ_CFG;
    r.op   = OP_INIT;
    r.addr = '0;
    r.cfg  = ResBits'(value);
    r.gap  = $urandom_range(0, 3);
    request_q.push_back(r);
  endfunction

  function automatic void add_drain();
    alloc_req_t r;
    r.kind = REQ_DRAIN;
    r.op   = OP_INIT;
    r.addr = '0;
    r.cfg  = '0;
    r.gap  = 0;
    request_q.push_back(r);
  endfunction

  function automatic logic [OpBits-1:0] draw_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_INIT;
    if (r < 27) return OP_ALLOC;
    if (r < 47) return OP_ALLOC_AT;
    if (r < 72) return OP_FREE;
    if (r < 94) return OP_QUERY;
    return OpBits'($urandom_range(int'(OP_QUERY) + 1, int'(OP_TOP)));
  endfunction

  // addresses cluster just around the reserved boundary, where allocs land
  function automatic logic [31:0] draw_addr(input int unsigned reserved);
    int unsigned r;
    int unsigned lo;
    int unsigned page;
    r  = $urandom_range(0, 99);
    lo = (reserved > 16) ? reserved - 16 : 0;
    if (r < 60) page = lo + $urandom_range(0, 191);
    else if (r < 70) page = $urandom_range(0, 63);
    else if (r < 82) page = $urandom_range(0, MaxPages - 1);
    else if (r < 90) page = MaxPages - 4 + $urandom_range(0, 7);
    else return $urandom();
    return {20'(page), 12'($urandom())};
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(page_map_outcome(s_axis_tuser, s_axis_tdata));
        requests_done++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_reserved = cfg_data_i;
        cfg_writes++;
      end
      if ((s_axis_tvalid && !s_axis_tready) || (cfg_valid_i && !cfg_ready_o)) begin
        valid_nxt = s_axis_tvalid;
        cfg_nxt   = cfg_valid_i;
      end else begin
        valid_nxt = 1'b0;
        cfg_nxt   = 1'b0;
        if (!have_req && request_q.size() != 0) begin
          cur_req  = request_q.pop_front();
          have_req = 1'b1;
          gap_left = cur_req.gap;
        end
        if (have_req) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            case (cur_req.kind)
              REQ_ITEM: begin
                valid_nxt = 1'b1;
                s_axis_tdata <= cur_req.addr;
                s_axis_tuser <= cur_req.op;
                have_req = 1'b0;
              end
              REQ_CFG: begin
                // register writes only once the block has gone quiet
                if (outcome_q.size() == 0) begin
                  cfg_nxt = 1'b1;
                  cfg_data_i <= cur_req.cfg;
                  have_req = 1'b0;
                end
              end
              default: begin
                if (outcome_q.size() == 0) have_req = 1'b0;
              end
            endcase
          end
        end
      end
      s_axis_tvalid <= valid_nxt;
      cfg_valid_i   <= cfg_nxt;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    frame_outcome_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        status_hits[m_axis_tuser]++;
        if (outcome_q.size() == 0) begin
          $error("unexpected transaction: page_address %h status %0d page_free %0d",
                 m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[32]);
          mismatches++;
        end else begin
          exp_res = outcome_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_res.page_address) begin
            $error("page_address: expected %h, got %h", exp_res.page_address,
                   m_axis_tdata[31:0]);
            mismatches++;
          end
          if (m_axis_tuser !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[32] !== exp_res.page_free) begin
            $error("page_free: expected %0d, got %0d", exp_res.page_free, m_axis_tdata[32]);
            mismatches++;
          end
        end
        if (sink_calm != 0) sink_calm--;
        else if ($urandom_range(0, 49) == 0) sink_calm = $urandom_range(20, 60);
        sink_stall = (sink_calm != 0) ? 0 : $urandom_range(0, 3);
      end else if (sink_stall != 0) begin
        sink_stall--;
      end else if (sink_calm == 0 && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(1, 3);
      end
      m_axis_tready <= (sink_stall == 0);
    end
  end

  initial begin
    #(TimeoutNs);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned random_items;
    int unsigned phase;
    int unsigned res_val;
    int unsigned budget;

    // directed: empty map, reserved region of zero pages
    add_item(OP_QUERY, 32'h0000_0ABC);
    add_item(OP_ALLOC, 32'hFFFF_FFFF);
    add_item(OP_ALLOC, 32'h0000_0000);
    add_item(OP_ALLOC_AT, 32'h0000_5FFF);
    add_item(OP_ALLOC_AT, 32'h0000_5000);
    add_item(OP_FREE, 32'h0000_1ABC);
    add_item(OP_FREE, 32'h0000_1000);
    add_item(OP_QUERY, 32'h0000_5000);
    add_item(OP_QUERY, 32'hFFFF_FFFF);
    add_item(OP_ALLOC_AT, FirstOutAddr);
    add_item(OP_FREE, LastPageAddr);
    add_item(OP_ALLOC_AT, LastPageAddr | 32'h0000_0FFF);
    add_item(OP_FREE, FirstOutAddr);
    add_item(OP_QUERY + 3'd1, 32'hFFFF_FFFF);
    add_item(OP_TOP, 32'h0000_0000);
    // protected low pages
    add_cfg(40);
    add_item(OP_INIT, 32'h0000_0000);
    add_item(OP_FREE, 32'h0002_7000);
    add_item(OP_FREE, 32'h0002_8000);
    add_item(OP_ALLOC, 32'h0000_0000);
    add_item(OP_QUERY, 32'h0002_7FFF);
    // whole map reserved: alloc runs dry
    add_cfg(MaxPages);
    add_item(OP_INIT, 32'hFFFF_FFFF);
    add_item(OP_ALLOC, 32'h0000_0000);
    add_item(OP_FREE, LastPageAddr);
    add_item(OP_QUERY, 32'h0000_0000);
    add_drain();

    random_items = 0;
    phase = 0;
    while (random_items < RandomItems) begin
      case (phase % 8)
        0: res_val = 0;
        1: res_val = 33;
        2: res_val = MaxPages;
        3: res_val = $urandom_range(0, 96);
        4: res_val = 32;
        5: res_val = 1;
        6: res_val = $urandom_range(0, MaxPages);
        default: res_val = 31;
      endcase
      // long alloc scans when many pages are reserved, so keep those phases short
      budget = (res_val > 4096) ? 60 : 250;
      add_cfg(res_val);
      add_item(OP_INIT, $urandom());
      for (int unsigned k = 0; k < budget; k++) begin
        if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
        if ($urandom_range(0, 99) == 0) add_drain();
        add_item(draw_op(), draw_addr(res_val));
      end
      random_items += budget + 1;
      phase++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || have_req || s_axis_tvalid || cfg_valid_i ||
           outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests, %0d register writes and %0d checked responses",
             requests_done, cfg_writes, results_seen);
    $display("statuses seen: ok %0d, no free %0d, not free %0d, protected %0d, %s %0d, %s %0d",
             status_hits[ST_OK], status_hits[ST_NO_FREE], status_hits[ST_NOT_FREE],
             status_hits[ST_PROTECTED], "double free", status_hits[ST_DOUBLE],
             "out of range", status_hits[ST_RANGE]);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
